// ----- hw/rtl/rgbhsv_pkg.sv -----
// Shared types and constants for the RGB to HSV pixel converter.
// Depends on nothing; used by rgb_to_hsv_pixel, hsv_result_checker and tb_top.
package rgbhsv_pkg;

	localparam int CH_W    = 8;   // one color channel
	localparam int HUE_W   = 9;   // hue in degrees, 0..359
	localparam int PCT_W   = 7;   // percent, 0..100
	localparam int DIFF_W  = 9;   // a - b + d, 0..510
	localparam int NUM_W   = 15;  // scaled numerators, below 2**15
	localparam int QBITS   = 7;   // quotient bits, both quotients stay below 128

	localparam int STAGES  = 10;  // s1 sort, s2 scale, s3..s9 divide, s10 result

	localparam logic [NUM_W-1:0] HUE_SCALE = NUM_W'(60);
	localparam logic [NUM_W-1:0] PCT_SCALE = NUM_W'(100);
	localparam logic [HUE_W-1:0] HUE_RED_LOW_OFS = HUE_W'(300);
	localparam logic [HUE_W-1:0] HUE_RED_OFS     = HUE_W'(60);
	localparam logic [HUE_W-1:0] HUE_GRN_OFS     = HUE_W'(60);
	localparam logic [HUE_W-1:0] HUE_BLU_OFS     = HUE_W'(180);
	localparam logic [QBITS-1:0] HUE_RED_WRAP    = QBITS'(60);

	// which channel holds the maximum, red winning ties over green over blue
	typedef enum logic [1:0] {
		HUE_RED,
		HUE_GRN,
		HUE_BLU
	} hue_br_t;

endpackage

// ----- hw/rtl/rgb_to_hsv_pixel.sv -----
// RGB to HSV pixel converter: ten-stage pipeline with two bit-per-stage dividers.
// Depends on rgbhsv_pkg for widths, scale constants and the hue branch type.
//
// Usage:
//   Slave stream s_axis_* carries one pixel per beat (blue, green, red bytes).
//   Master stream s_axis_* counterpart m_axis_* returns one beat per pixel with
//   hue in degrees and saturation and value in floored percent, in order.
//   An accepted input beat passes the s1 to s10 registers. Throughput is one
//   pixel per clock while m_axis_tready is high; the two restoring dividers
//   (hue over the channel spread, saturation over the maximum) resolve one
//   quotient bit per stage across s3..s9, so they set the depth but not the rate.
//   Every stage carries its own valid bit and advances when it is empty or the
//   stage after it advances, so bubbles are squeezed out and s_axis_tready
//   stays high while the pipeline has any empty slot, even with a stalled
//   output beat waiting.
//   When m_axis_tready is low, the output beat holds, and stages fill up
//   behind it; no beat is dropped or repeated.
//   Reset (arst_n low) clears all valid bits at once; data registers are not
//   reset. The block is ready for input right after reset.
module rgb_to_hsv_pixel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [7:0] blue_in, [15:8] green_in, [23:16] red_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // [8:0] hue_deg, [15:9] sat_pct, [22:16] val_pct, [23] 0
);

	localparam int NS = rgbhsv_pkg::STAGES;
	localparam int CW = rgbhsv_pkg::CH_W;
	localparam int NW = rgbhsv_pkg::NUM_W;
	localparam int QW = rgbhsv_pkg::QBITS;
	localparam int HW = rgbhsv_pkg::HUE_W;
	localparam int PW = rgbhsv_pkg::PCT_W;
	localparam int DW = rgbhsv_pkg::DIFF_W;

	// per-stage valid bits and advance enables
	logic [NS:1] vld_s;
	logic [NS:1] adv;

	// unpacked input fields
	logic [CW-1:0] blue_in, green_in, red_in;

	assign blue_in  = s_axis_tdata[CW-1:0];
	assign green_in = s_axis_tdata[2*CW-1:CW];
	assign red_in   = s_axis_tdata[3*CW-1:2*CW];

	// ---------------------------------------------------------------------
	// Flow control: a stage advances when empty or when its successor does.
	// ---------------------------------------------------------------------
	always_comb begin
		adv[NS] = !vld_s[NS] || m_axis_tready;
		for (int i = NS - 1; i >= 1; i--) begin
			adv[i] = !vld_s[i] || adv[i+1];
		end
	end

	assign s_axis_tready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[1]) begin
				vld_s[1] <= s_axis_tvalid;
			end
			for (int i = 2; i <= NS; i++) begin
				if (adv[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// s1: sort channels, pick the hue branch, form the spread and hue offset
	// numerator a - b + d (never negative since |a - b| <= d).
	// ---------------------------------------------------------------------
	logic [CW-1:0]       mx_c, mn_c;
	rgbhsv_pkg::hue_br_t br_c;
	logic [DW-1:0]       ha_c, hb_c;

	always_comb begin
		if (red_in >= green_in && red_in >= blue_in) begin
			br_c = rgbhsv_pkg::HUE_RED;
			mx_c = red_in;
			ha_c = DW'(green_in);
			hb_c = DW'(blue_in);
		end else if (green_in >= blue_in) begin
			br_c = rgbhsv_pkg::HUE_GRN;
			mx_c = green_in;
			ha_c = DW'(blue_in);
			hb_c = DW'(red_in);
		end else begin
			br_c = rgbhsv_pkg::HUE_BLU;
			mx_c = blue_in;
			ha_c = DW'(red_in);
			hb_c = DW'(green_in);
		end
		mn_c = red_in;
		if (green_in < mn_c) mn_c = green_in;
		if (blue_in < mn_c)  mn_c = blue_in;
	end

	logic [CW-1:0]       mx_s1, d_s1;
	logic [DW-1:0]       hdiff_s1;
	rgbhsv_pkg::hue_br_t br_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			mx_s1    <= mx_c;
			d_s1     <= mx_c - mn_c;
			hdiff_s1 <= ha_c + DW'(mx_c - mn_c) - hb_c;
			br_s1    <= br_c;
		end
	end

	// ---------------------------------------------------------------------
	// s2 .. s9: divider lanes. s2 holds the scaled numerators; each of s3..s9
	// resolves one quotient bit, most significant first.
	// ---------------------------------------------------------------------
	logic [NW-1:0]       hrem_s [2:9];
	logic [NW-1:0]       srem_s [2:9];
	logic [QW-1:0]       hq_s   [2:9];
	logic [QW-1:0]       sq_s   [2:9];
	logic [CW-1:0]       hdiv_s [2:9];
	logic [CW-1:0]       sdiv_s [2:9];
	logic [PW-1:0]       val_s  [2:9];
	logic                gray_s [2:9];
	rgbhsv_pkg::hue_br_t br_s   [2:9];

	// value = floor(100*mx/255) via x/255 = (x + (x >> 8) + 1) >> 8, exact here
	logic [NW-1:0] vnum_c, vsum_c;

	assign vnum_c = NW'(mx_s1) * rgbhsv_pkg::PCT_SCALE;
	assign vsum_c = vnum_c + (vnum_c >> 8) + NW'(1);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			hrem_s[2] <= NW'(hdiff_s1) * rgbhsv_pkg::HUE_SCALE;
			srem_s[2] <= NW'(d_s1) * rgbhsv_pkg::PCT_SCALE;
			hq_s[2]   <= '0;
			sq_s[2]   <= '0;
			hdiv_s[2] <= d_s1;
			sdiv_s[2] <= mx_s1;
			val_s[2]  <= vsum_c[NW-1:8];
			gray_s[2] <= (d_s1 == '0);
			br_s[2]   <= br_s1;
		end
	end

	for (genvar gi = 3; gi <= 9; gi++) begin : g_div
		localparam int B = 9 - gi;   // quotient bit resolved in this stage

		logic [NW-1:0] htrial, strial;
		logic          hge, sge;

		assign htrial = NW'(hdiv_s[gi-1]) << B;
		assign strial = NW'(sdiv_s[gi-1]) << B;
		assign hge    = hrem_s[gi-1] >= htrial;
		assign sge    = srem_s[gi-1] >= strial;

		always_ff @(posedge clk) begin
			if (adv[gi]) begin
				hrem_s[gi] <= hge ? hrem_s[gi-1] - htrial : hrem_s[gi-1];
				srem_s[gi] <= sge ? srem_s[gi-1] - strial : srem_s[gi-1];
				hq_s[gi]   <= {hq_s[gi-1][QW-2:0], hge};
				sq_s[gi]   <= {sq_s[gi-1][QW-2:0], sge};
				hdiv_s[gi] <= hdiv_s[gi-1];
				sdiv_s[gi] <= sdiv_s[gi-1];
				val_s[gi]  <= val_s[gi-1];
				gray_s[gi] <= gray_s[gi-1];
				br_s[gi]   <= br_s[gi-1];
			end
		end
	end

	// ---------------------------------------------------------------------
	// s10: place the quotient in the branch's sector; gray pixels get zero
	// hue and saturation. The divide-by-zero quotients are dropped there.
	// ---------------------------------------------------------------------
	logic [HW-1:0] hue_c;
	logic [HW-1:0] hq9;

	assign hq9 = HW'(hq_s[9]);

	always_comb begin
		unique case (br_s[9])
			rgbhsv_pkg::HUE_RED: begin
				if (hq_s[9] < rgbhsv_pkg::HUE_RED_WRAP) begin
					hue_c = hq9 + rgbhsv_pkg::HUE_RED_LOW_OFS;
				end else begin
					hue_c = hq9 - rgbhsv_pkg::HUE_RED_OFS;
				end
			end
			rgbhsv_pkg::HUE_GRN: hue_c = hq9 + rgbhsv_pkg::HUE_GRN_OFS;
			rgbhsv_pkg::HUE_BLU: hue_c = hq9 + rgbhsv_pkg::HUE_BLU_OFS;
			default:             hue_c = '0;
		endcase
	end

	logic [HW-1:0] hue_s10;
	logic [PW-1:0] sat_s10, val_s10;

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			hue_s10 <= gray_s[9] ? '0 : hue_c;
			sat_s10 <= gray_s[9] ? '0 : sq_s[9];
			val_s10 <= val_s[9];
		end
	end

	assign m_axis_tvalid = vld_s[NS];
	assign m_axis_tdata  = {1'b0, val_s10, sat_s10, hue_s10};

endmodule

// ----- tb/sv/hsv_result_checker.sv -----
// Checker for the RGB to HSV pixel converter: watches both streams, predicts each result.
// Depends on rgbhsv_pkg for field widths; instantiated by tb_top.
`timescale 1ns / 100ps

module hsv_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [23:0] in_data,    // [7:0] blue, [15:8] green, [23:16] red
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [23:0] out_data,   // [8:0] hue, [15:9] sat, [22:16] val, [23] pad
	output int          fail_cnt,
	output int          due_cnt,
	output int          checked_cnt
);

	localparam int HW = rgbhsv_pkg::HUE_W;
	localparam int PW = rgbhsv_pkg::PCT_W;

	typedef struct packed {
		logic          pad;
		logic [PW-1:0] val;
		logic [PW-1:0] sat;
		logic [HW-1:0] hue;
	} hsv_t;

	// accepted pixels whose result is still outstanding, oldest first
	logic [23:0] pixel_q[$];

	// floor(60*(a-b)/d); a-b+d is never negative, so plain division floors
	function automatic int hue_slope(int a, int b, int d);
		return (60 * (a - b + d)) / d - 60;
	endfunction

	function automatic hsv_t hsv_predict(logic [23:0] px);
		int   bl, gr, rd, mx, mn, d, h;
		hsv_t o;
		bl = px[7:0];
		gr = px[15:8];
		rd = px[23:16];
		mx = rd;
		mn = rd;
		if (gr > mx) mx = gr;
		if (bl > mx) mx = bl;
		if (gr < mn) mn = gr;
		if (bl < mn) mn = bl;
		d = mx - mn;
		o = '0;
		o.val = PW'((100 * mx) / 255);
		if (d != 0) begin
			o.sat = PW'((100 * d) / mx);
			// red wins ties over green, green over blue
			if (mx == rd) begin
				h = hue_slope(gr, bl, d);
				if (h < 0) h += 360;
			end else if (mx == gr) begin
				h = 120 + hue_slope(bl, rd, d);
			end else begin
				h = 240 + hue_slope(rd, gr, d);
			end
			o.hue = HW'(h);
		end
		return o;
	endfunction

	task automatic report_field(string fname, logic [23:0] px, int want, int got);
		if (want != got) begin
			fail_cnt++;
			$display("%0t: %s mismatch for pixel r=%0d g=%0d b=%0d: expected %0d, got %0d",
				$time, fname, px[23:16], px[15:8], px[7:0], want, got);
		end
	endtask

	always @(posedge clk) begin
		logic [23:0] px;
		hsv_t        want, got;
		if (arst_n) begin
			if (in_valid && in_ready)
				pixel_q.push_back(in_data);
			if (out_valid && out_ready) begin
				got = out_data;
				if (pixel_q.size() == 0) begin
					fail_cnt++;
					$display("%0t: unexpected result beat: expected none, got %h", $time, out_data);
				end else begin
					px   = pixel_q.pop_front();
					want = hsv_predict(px);
					report_field("hue", px, want.hue, got.hue);
					report_field("sat", px, want.sat, got.sat);
					report_field("val", px, want.val, got.val);
					report_field("pad", px, want.pad, got.pad);
					checked_cnt++;
				end
			end
			due_cnt = pixel_q.size();
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the RGB to HSV converter testbench: clock, reset, pixel stimulus and verdict.
// Depends on rgb_to_hsv_pixel, rgbhsv_pkg and hsv_result_checker.
`timescale 1ns / 100ps

module tb_top;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;    // [7:0] blue, [15:8] green, [23:16] red
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;    // [8:0] hue, [15:9] sat, [22:16] val, [23] pad

	int fail_cnt;
	int due_cnt;
	int checked_cnt;
	int sent_cnt;
	int directed_cnt;

	// calm phases: no idle cycles on the respective side
	logic tx_calm = 1'b0;
	logic rx_calm = 1'b0;
	int   rx_hold = 0;

	always #5 clk = ~clk;

	rgb_to_hsv_pixel u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata)
	);

	hsv_result_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_data     (s_tdata),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (m_tdata),
		.fail_cnt    (fail_cnt),
		.due_cnt     (due_cnt),
		.checked_cnt (checked_cnt)
	);

	// Gap length: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] corner_byte();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	// Random pixel as {red, green, blue}. Bias toward gray, tied maxima,
	// corner values and near-gray spreads, where the branch logic is tightest.
	function automatic logic [23:0] random_pixel();
		logic [7:0] r, g, b, hi, lo;
		case ($urandom_range(0, 9))
			0: begin
				r = 8'($urandom_range(0, 255));
				g = r;
				b = r;
			end
			1: begin
				hi = 8'($urandom_range(1, 255));
				lo = 8'($urandom_range(0, hi));
				case ($urandom_range(0, 2))
					0: {r, g, b} = {hi, hi, lo};
					1: {r, g, b} = {lo, hi, hi};
					default: {r, g, b} = {hi, lo, hi};
				endcase
			end
			2: begin
				r = corner_byte();
				g = corner_byte();
				b = corner_byte();
			end
			3: begin
				lo = 8'($urandom_range(0, 250));
				r = 8'(lo + $urandom_range(0, 5));
				g = 8'(lo + $urandom_range(0, 5));
				b = 8'(lo + $urandom_range(0, 5));
			end
			default: begin
				r = 8'($urandom_range(0, 255));
				g = 8'($urandom_range(0, 255));
				b = 8'($urandom_range(0, 255));
			end
		endcase
		return {r, g, b};
	endfunction

	// Send one pixel beat. Enter and leave at a falling edge; hold the beat
	// until the block takes it, then drop valid.
	task automatic push_pixel(input logic [23:0] px);
		int gap;
		gap = tx_calm ? 0 : pick_gap();
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = px;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
		sent_cnt++;
	endtask

	// Hold off the sender until every outstanding result has come back.
	task automatic wait_drained();
		while (due_cnt != 0) @(negedge clk);
	endtask

	// Receiver: hold ready high or low for a random stretch, then pick again; in a calm phase, hold it high.
	always @(negedge clk) begin
		if (rx_calm) begin
			m_tready = 1'b1;
			rx_hold  = 0;
		end else if (rx_hold != 0) begin
			rx_hold = rx_hold - 1;
		end else begin
			m_tready = ($urandom_range(0, 2) != 0);
			rx_hold  = pick_gap();
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed pixels, written as {red, green, blue}.
		push_pixel(24'h000000);   // black
		push_pixel(24'hffffff);   // white
		push_pixel(24'h808080);   // mid gray
		push_pixel(24'h010101);   // darkest non-black gray
		push_pixel(24'hff0000);   // pure red
		push_pixel(24'h00ff00);   // pure green
		push_pixel(24'h0000ff);   // pure blue
		push_pixel(24'hff00ff);   // red and blue tie at max: red branch, wraps to 300
		push_pixel(24'hffff00);   // red and green tie: red wins
		push_pixel(24'h00ffff);   // green and blue tie: green wins
		push_pixel(24'hff00fe);   // blue just under red: deepest red wrap
		push_pixel(24'hff0001);   // tiny negative red slope: hue just under 360
		push_pixel(24'hff0100);   // tiny positive red slope
		push_pixel(24'h000001);   // blue max, value floors to zero
		push_pixel(24'h010000);   // red max, value floors to zero
		push_pixel(24'h0001ff);   // blue max, green above red: hue just under 240
		push_pixel(24'hfeffff);   // green branch with red one below
		push_pixel(24'h01ff00);   // green branch, red above blue
		push_pixel(24'haaaaab);   // near gray, blue max
		push_pixel(24'h55aa55);   // alternating bit patterns
		push_pixel(24'haa55aa);
		push_pixel(24'h7f80ff);
		directed_cnt = sent_cnt;

		// Pause the sender until the pipeline is empty at least once.
		wait_drained();

		repeat (700) push_pixel(random_pixel());
		wait_drained();

		// Stretch with no idling on either side: back-to-back beats.
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		repeat (300) push_pixel(random_pixel());
		tx_calm = 1'b0;
		rx_calm = 1'b0;

		repeat (650) push_pixel(random_pixel());

		wait_drained();
		repeat (3 * rgbhsv_pkg::STAGES) @(negedge clk);

		$display("Sent %0d pixels (%0d directed: grays, tied maxima, red wrap, corners),",
			sent_cnt, directed_cnt);
		$display("checked %0d results under random stalls and a stall-free stretch.",
			checked_cnt);
		if (fail_cnt == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this stimulus.
	initial begin
		#10_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/rgbhsv_pkg.sv
hw/rtl/rgb_to_hsv_pixel.sv
tb/sv/hsv_result_checker.sv
tb/sv/tb_top.sv
